// File: rtl/i2c_mbe_pkg.sv
package i2c_mbe_pkg;

  // Command codes; out-of-range actions classify as CMD_IDLE
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
  localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] PHASE_TICKS_RST    = 16'd100;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd10;

  // Tick queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

endpackage

// File: rtl/i2c_mbe_in_if.sv
interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       last_read;
  logic       sda_in;

  modport source (output valid, output action, output tx_byte, output last_read,
                  output sda_in, input ready);
  modport sink (input valid, input action, input tx_byte, input last_read,
                input sda_in, output ready);
endinterface

// File: rtl/i2c_mbe_out_if.sv
interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rx_byte, output ack_missing, input ready);
  modport sink (input valid, input scl_out, input sda_out, input busy_res,
                input done_res, input rx_byte, input ack_missing, output ready);
endinterface

// File: rtl/i2c_master_bit_engine.sv
// I2C master bit engine.
// in_ch carries one timing tick per transaction: the sampled SDA level and,
// while the engine is idle, an optional command (start, stop, write byte,
// read byte with ack or nack). Commands that arrive while busy are dropped.
// out_ch returns exactly one result per tick: SCL/SDA levels to drive, busy,
// a done pulse, the last read byte and the missing-acknowledge flag.
// The cfg port sets phase_ticks (index 0) and ack_poll_limit (index 1); write
// it only while idle.
// Throughput: one tick per clock while out_ch takes results. The front
// stage classifies the command and queues the tick (4 entries); the back
// stage runs the phase sequencer and its wait counter, one tick per cycle
// when not stalled, into an output register. A tick accepted into the queue
// is popped into the back stage; its result waits in the output register
// until taken. When out_ch stalls, the output register holds and the queue
// absorbs up to four more ticks before in_ch.ready drops.
// Reset (synchronous, active high) empties the queue, idles the sequencer,
// releases both lines high and restores the default register values.
module i2c_master_bit_engine #(
  parameter int WAIT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  i2c_mbe_in_if.sink                         in_ch,
  i2c_mbe_out_if.source                      out_ch,
  input  logic                               cfg_we,
  input  logic [i2c_mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2c_mbe_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic               q_valid;
  logic               q_pop;
  i2c_mbe_pkg::item_t q_item;

  i2c_mbe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  i2c_mbe_back #(
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/i2c_mbe_front.sv
module i2c_mbe_front (
  input  logic                clk,
  input  logic                rst,
  i2c_mbe_in_if.sink          in_ch,
  output logic                q_valid,
  output i2c_mbe_pkg::item_t  q_item,
  input  logic                q_pop
);

  i2c_mbe_pkg::item_t                  mem [i2c_mbe_pkg::Q_DEPTH];
  logic [i2c_mbe_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [i2c_mbe_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [i2c_mbe_pkg::Q_CNT_W-1:0]     count;
  logic                                push;
  i2c_mbe_pkg::item_t                  push_item;

  function automatic logic [i2c_mbe_pkg::Q_CNT_W-1:0] Q_CNT_W_one(input logic b);
    Q_CNT_W_one = {{(i2c_mbe_pkg::Q_CNT_W-1){1'b0}}, b};
  endfunction

  assign in_ch.ready = (count != i2c_mbe_pkg::Q_CNT_W'(i2c_mbe_pkg::Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign q_item      = mem[rd_ptr];

  // Classify the action; unused codes mean no command
  always_comb begin
    push_item.tx_byte   = in_ch.tx_byte;
    push_item.last_read = in_ch.last_read;
    push_item.sda_in    = in_ch.sda_in;
    case (in_ch.action)
      i2c_mbe_pkg::CMD_START: push_item.cmd = i2c_mbe_pkg::CMD_START;
      i2c_mbe_pkg::CMD_STOP:  push_item.cmd = i2c_mbe_pkg::CMD_STOP;
      i2c_mbe_pkg::CMD_WRITE: push_item.cmd = i2c_mbe_pkg::CMD_WRITE;
      i2c_mbe_pkg::CMD_READ:  push_item.cmd = i2c_mbe_pkg::CMD_READ;
      default:                push_item.cmd = i2c_mbe_pkg::CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W_one(push) - Q_CNT_W_one(q_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= i2c_mbe_pkg::Q_CNT_W'(i2c_mbe_pkg::Q_DEPTH))
    else $error("tick queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty tick queue");
`endif

endmodule

// File: rtl/i2c_mbe_back.sv
module i2c_mbe_back #(
  parameter int WAIT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [i2c_mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2c_mbe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                   q_valid,
  input  i2c_mbe_pkg::item_t                     q_item,
  output logic                                   q_pop,
  i2c_mbe_out_if.source                          out_ch
);

  logic [15:0]           phase_ticks;
  logic [7:0]            ack_poll_limit;

  i2c_mbe_pkg::cmd_t     command_reg, command_next;
  logic [2:0]            phase_step, phase_next;
  logic [WAIT_WIDTH-1:0] wait_count, wait_next;
  logic [3:0]            bit_index, bit_next;
  logic [7:0]            shift_byte, shift_next;
  logic [7:0]            poll_count, poll_next;
  logic                  nack_after, nack_next;
  logic                  scl_level, scl_next;
  logic                  sda_level, sda_next;
  logic                  ack_flag, ack_next;
  logic [7:0]            rx_hold, rx_next;
  logic                  done;
  logic                  run_phase;
  logic                  load_wait;

  logic                  out_valid;
  i2c_mbe_pkg::res_t     res;

  logic [WAIT_WIDTH+15:0] ticks_ext;
  logic [WAIT_WIDTH-1:0]  ticks_raw;
  logic [WAIT_WIDTH-1:0]  load_val;

  assign ticks_ext = {{WAIT_WIDTH{1'b0}}, phase_ticks};
  assign ticks_raw = ticks_ext[WAIT_WIDTH-1:0];
  assign load_val  = (ticks_raw == '0) ? WAIT_WIDTH'(1) : ticks_raw;

  assign q_pop = q_valid && (!out_valid || out_ch.ready);

  always_comb begin
    command_next = command_reg;
    phase_next   = phase_step;
    wait_next    = wait_count;
    bit_next     = bit_index;
    shift_next   = shift_byte;
    poll_next    = poll_count;
    nack_next    = nack_after;
    scl_next     = scl_level;
    sda_next     = sda_level;
    ack_next     = ack_flag;
    rx_next      = rx_hold;
    done         = 1'b0;
    run_phase    = 1'b0;
    load_wait    = 1'b0;

    if (command_reg == i2c_mbe_pkg::CMD_IDLE) begin
      if (q_item.cmd != i2c_mbe_pkg::CMD_IDLE) begin
        command_next = q_item.cmd;
        phase_next   = '0;
        bit_next     = '0;
        poll_next    = '0;
        if (q_item.cmd == i2c_mbe_pkg::CMD_WRITE) begin
          shift_next = q_item.tx_byte;
        end
        if (q_item.cmd == i2c_mbe_pkg::CMD_READ) begin
          nack_next = q_item.last_read;
        end
        run_phase = 1'b1;
      end
    end else begin
      wait_next = wait_count - 1'b1;
      if (wait_next == '0) begin
        // Phase wait ran out: advance the sequence or finish the command
        run_phase = 1'b1;
        case (command_reg)
          i2c_mbe_pkg::CMD_START: begin
            if (phase_step >= 3'd4) begin
              done = 1'b1;
            end else begin
              phase_next = phase_step + 1'b1;
            end
          end
          i2c_mbe_pkg::CMD_STOP: begin
            if (phase_step >= 3'd2) begin
              done = 1'b1;
            end else begin
              phase_next = phase_step + 1'b1;
            end
          end
          i2c_mbe_pkg::CMD_WRITE: begin
            if (phase_step == 3'd2) begin
              bit_next   = bit_index + 1'b1;
              phase_next = (bit_next < 4'd8) ? 3'd0 : 3'd3;
            end else if (phase_step == 3'd6) begin
              phase_next = 3'd6;
            end else if (phase_step >= 3'd7) begin
              done = 1'b1;
            end else begin
              phase_next = phase_step + 1'b1;
            end
          end
          i2c_mbe_pkg::CMD_READ: begin
            if (phase_step == 3'd2) begin
              bit_next   = bit_index + 1'b1;
              phase_next = (bit_next < 4'd8) ? 3'd1 : 3'd3;
            end else if (phase_step >= 3'd5) begin
              done = 1'b1;
            end else begin
              phase_next = phase_step + 1'b1;
            end
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          run_phase = 1'b0;
        end
      end
    end

    // Drive the line change of the phase just entered
    if (run_phase) begin
      load_wait = 1'b1;
      case (command_next)
        i2c_mbe_pkg::CMD_START: begin
          case (phase_next)
            3'd0:    scl_next = 1'b0;
            3'd1:    sda_next = 1'b1;
            3'd2:    scl_next = 1'b1;
            3'd3:    sda_next = 1'b0;
            default: scl_next = 1'b0;
          endcase
        end
        i2c_mbe_pkg::CMD_STOP: begin
          case (phase_next)
            3'd0:    sda_next = 1'b0;
            3'd1:    scl_next = 1'b1;
            default: sda_next = 1'b1;
          endcase
        end
        i2c_mbe_pkg::CMD_WRITE: begin
          case (phase_next)
            3'd0, 3'd3: scl_next = 1'b0;
            3'd1:       sda_next = shift_next[3'd7 - bit_next[2:0]];
            3'd2, 3'd5: scl_next = 1'b1;
            3'd4:       sda_next = 1'b1;
            default: begin
              // Acknowledge poll
              if (!q_item.sda_in) begin
                scl_next   = 1'b0;
                ack_next   = 1'b0;
                phase_next = 3'd7;
              end else if (poll_count > ack_poll_limit || poll_count == 8'hFF) begin
                scl_next  = 1'b0;
                ack_next  = 1'b1;
                done      = 1'b1;
                load_wait = 1'b0;
              end else begin
                poll_next = poll_count + 1'b1;
              end
            end
          endcase
        end
        i2c_mbe_pkg::CMD_READ: begin
          case (phase_next)
            3'd0:       sda_next = 1'b1;
            3'd1, 3'd4: scl_next = 1'b1;
            3'd2: begin
              shift_next = {shift_byte[6:0], q_item.sda_in};
              scl_next   = 1'b0;
            end
            3'd3: begin
              rx_next  = shift_byte;
              sda_next = nack_after;
            end
            default:    scl_next = 1'b0;
          endcase
        end
        default: begin
          done      = 1'b1;
          load_wait = 1'b0;
        end
      endcase
    end

    if (load_wait) begin
      wait_next = load_val;
    end

    if (done) begin
      command_next = i2c_mbe_pkg::CMD_IDLE;
      phase_next   = '0;
      wait_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= i2c_mbe_pkg::PHASE_TICKS_RST;
      ack_poll_limit <= i2c_mbe_pkg::ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2c_mbe_pkg::REG_PHASE_TICKS:    phase_ticks    <= cfg_data;
        i2c_mbe_pkg::REG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg <= i2c_mbe_pkg::CMD_IDLE;
      phase_step  <= '0;
      wait_count  <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      poll_count  <= '0;
      nack_after  <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      ack_flag    <= 1'b0;
      rx_hold     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        command_reg <= command_next;
        phase_step  <= phase_next;
        wait_count  <= wait_next;
        bit_index   <= bit_next;
        shift_byte  <= shift_next;
        poll_count  <= poll_next;
        nack_after  <= nack_next;
        scl_level   <= scl_next;
        sda_level   <= sda_next;
        ack_flag    <= ack_next;
        rx_hold     <= rx_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.scl_out     <= scl_next;
      res.sda_out     <= sda_next;
      res.busy_res    <= (command_next != i2c_mbe_pkg::CMD_IDLE);
      res.done_res    <= done;
      res.rx_byte     <= rx_next;
      res.ack_missing <= ack_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.scl_out     = res.scl_out;
  assign out_ch.sda_out     = res.sda_out;
  assign out_ch.busy_res    = res.busy_res;
  assign out_ch.done_res    = res.done_res;
  assign out_ch.rx_byte     = res.rx_byte;
  assign out_ch.ack_missing = res.ack_missing;

`ifndef NO_ASSERTIONS
  a_idle_no_wait: assert property (@(posedge clk) disable iff (rst)
    (command_reg == i2c_mbe_pkg::CMD_IDLE) |-> (wait_count == '0))
    else $error("wait counter running while idle");
  a_busy_wait_live: assert property (@(posedge clk) disable iff (rst)
    (command_reg != i2c_mbe_pkg::CMD_IDLE) |-> (wait_count != '0))
    else $error("busy with expired wait counter");
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'd8)
    else $error("bit index past byte end");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.done_res) |-> !res.busy_res)
    else $error("completion reported while busy");
`endif

endmodule
